>>> sv/tmdc_pkg.sv
// shared constants and types for the trimmed mean dust concentration block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tmdc_pkg;

    localparam int SAMPLE_COUNT = 20;
    localparam int DATA_W       = 12;
    localparam int IDX_W        = $clog2(SAMPLE_COUNT);
    localparam int SUM_W        = DATA_W + $clog2(SAMPLE_COUNT);
    localparam int PROD_W       = 2 * DATA_W;

    // divide by the group size less two as multiply by a rounded-up reciprocal
    localparam int DIVISOR     = SAMPLE_COUNT - 2;
    localparam int RECIP_SHIFT = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int QPROD_W     = SUM_W + RECIP_W;

    localparam logic [DATA_W-1:0]  GAIN_RESET = DATA_W'(429);
    localparam logic [DATA_W-1:0]  MIN_RESET  = {DATA_W{1'b1}};
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(SAMPLE_COUNT - 1);
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'(((2 ** RECIP_SHIFT) + DIVISOR - 1) / DIVISOR);
    localparam int                 Q_DEPTH    = 2;
    localparam int                 QP_W       = $clog2(Q_DEPTH);

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] tsum;
    } t_qpush;

endpackage
`default_nettype wire

>>> sv/tmdc_front.sv
// front part: accepts samples, keeps running sum, minimum and maximum
// uses tmdc_pkg; pushes the trimmed sum of each group into tmdc_queue
`timescale 1ns / 1ps
`default_nettype none
module tmdc_front
    import tmdc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [DATA_W-1:0] i_sample,
    input  wire logic              i_q_full,
    output t_qpush                 o_push
);

    logic [IDX_W-1:0]  r_idx;
    logic [SUM_W-1:0]  r_sum;
    logic [DATA_W-1:0] r_min;
    logic [DATA_W-1:0] r_max;

    logic [SUM_W-1:0]  n_sum;
    logic [DATA_W-1:0] n_min;
    logic [DATA_W-1:0] n_max;
    logic              w_xfer;
    logic              w_last;

    assign o_ready = !i_q_full;
    assign w_xfer  = i_valid && o_ready;
    assign w_last  = (r_idx == LAST_IDX);

    always_comb begin
        n_sum = r_sum + SUM_W'(i_sample);
        n_min = (i_sample < r_min) ? i_sample : r_min;
        n_max = (i_sample > r_max) ? i_sample : r_max;
    end

    assign o_push.valid = w_xfer && w_last;
    assign o_push.tsum  = n_sum - SUM_W'(n_min) - SUM_W'(n_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_sum <= '0;
            r_min <= MIN_RESET;
            r_max <= '0;
        end else if (w_xfer) begin
            if (w_last) begin
                r_idx <= '0;
                r_sum <= '0;
                r_min <= MIN_RESET;
                r_max <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
                r_sum <= n_sum;
                r_min <= n_min;
                r_max <= n_max;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/tmdc_queue.sv
// two-entry queue of trimmed group sums between front and back parts
// uses tmdc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tmdc_queue
    import tmdc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_qpush           i_push,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [SUM_W-1:0]      o_data
);

    logic [SUM_W-1:0] r_mem [Q_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr;
    logic [QP_W:0]    r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == (QP_W + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push.valid && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.tsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/tmdc_back.sv
// back part: divides the trimmed sum by the group size less two with a reciprocal
// multiply, scales by gain and holds the result; uses tmdc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tmdc_back
    import tmdc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire logic [SUM_W-1:0]  i_q_data,
    output logic                   o_pop,
    input  wire logic [DATA_W-1:0] i_gain,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [DATA_W-1:0]      o_trimmed_average,
    output logic [DATA_W-1:0]      o_concentration
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_HOLD
    } t_state;

    t_state             r_state;
    logic [SUM_W-1:0]   r_rem;
    logic [DATA_W-1:0]  r_quo;
    logic [QPROD_W-1:0] w_qprod;
    logic [PROD_W-1:0]  w_prod;

    assign o_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign w_qprod = QPROD_W'(r_rem) * QPROD_W'(RECIP_MULT);
    assign w_prod  = PROD_W'(r_quo) * PROD_W'(i_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_rem   <= i_q_data;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo   <= w_qprod[RECIP_SHIFT +: DATA_W];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    o_trimmed_average <= r_quo;
                    o_concentration   <= w_prod[PROD_W-1:DATA_W];
                    o_valid           <= 1'b1;
                    r_state           <= S_HOLD;
                end
                S_HOLD: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/trimmed_mean_dust_concentration_top.sv
// top level: trimmed mean of each group of samples and dust concentration
// after the transfer of a group's last sample, its trimmed sum passes the queue, r_rem and r_quo before o_valid
// throughput: one sample per cycle while the queue is not full; each group result passes the back part's
// reciprocal multiply, gain multiply and output hold, and the two-entry queue absorbs stalls
// reset: synchronous active low, clears counters, queue, output valid; gain to 429
// uses tmdc_pkg, tmdc_front, tmdc_queue, tmdc_back
`timescale 1ns / 1ps
`default_nettype none
module trimmed_mean_dust_concentration_top
    import tmdc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [DATA_W-1:0] i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [DATA_W-1:0] i_sample,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [DATA_W-1:0]      o_trimmed_average,
    output logic [DATA_W-1:0]      o_concentration
);

    logic [DATA_W-1:0] r_gain;
    t_qpush            w_push;
    logic              w_q_full;
    logic              w_q_empty;
    logic [SUM_W-1:0]  w_q_data;
    logic              w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    tmdc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .i_q_full (w_q_full),
        .o_push   (w_push)
    );

    tmdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    tmdc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (w_q_empty),
        .i_q_data          (w_q_data),
        .o_pop             (w_pop),
        .i_gain            (r_gain),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_trimmed_average (o_trimmed_average),
        .o_concentration   (o_concentration)
    );

endmodule
`default_nettype wire

>>> dv/trimmed_mean_dust_concentration_top_test.sv
// self-checking testbench for trimmed_mean_dust_concentration_top: directed group table,
// then random sample phases with gain changes, checked against table results or an in-bench group predictor
// depends on tmdc_pkg and the top level only
`timescale 1ns / 1ps
`default_nettype none
module trimmed_mean_dust_concentration_top_test;
    import tmdc_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_WAIT  = 40;

    typedef struct packed {
        logic [DATA_W-1:0] avg;
        logic [DATA_W-1:0] conc;
    } group_result_t;

    typedef struct {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] last;
        bit                gain_we;
        logic [DATA_W-1:0] gain;
        bit                mid_we;
        logic [DATA_W-1:0] mid_gain;
        bit                typed;
        logic [DATA_W-1:0] exp_avg;
        logic [DATA_W-1:0] exp_conc;
    } group_row_t;

    typedef enum int {SRC_UNIFORM, SRC_CLUSTER, SRC_EXTREME, SRC_FLAT} sample_src_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [DATA_W-1:0] i_cfg_wdata;
    logic              i_valid;
    logic              o_ready;
    logic [DATA_W-1:0] i_sample;
    logic              o_valid;
    logic              i_ready;
    logic [DATA_W-1:0] o_trimmed_average;
    logic [DATA_W-1:0] o_concentration;

    trimmed_mean_dust_concentration_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_trimmed_average (o_trimmed_average),
        .o_concentration   (o_concentration)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // group predictor state
    logic [IDX_W:0]    tm_count;
    logic [SUM_W-1:0]  tm_sum;
    logic [DATA_W-1:0] tm_min;
    logic [DATA_W-1:0] tm_max;
    logic [DATA_W-1:0] tm_gain;

    group_result_t pending_results[$];
    bit            typed_on;
    group_result_t typed_res;

    int mismatches   = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int gain_writes  = 0;
    int burst_left   = 0;
    bit hold_go      = 1'b0;
    bit hold_done    = 1'b0;

    sample_src_t       src_mode;
    logic [DATA_W-1:0] src_center;

    group_row_t rows [10] = '{
        '{12'd0,    12'd0,    12'd0,    1'b0, 12'd0,    1'b0, 12'd0,   1'b1, 12'd0,    12'd0},
        '{12'd4095, 12'd4095, 12'd4095, 1'b0, 12'd0,    1'b0, 12'd0,   1'b1, 12'd4095, 12'd428},
        '{12'd4095, 12'd4095, 12'd4095, 1'b1, 12'd4095, 1'b0, 12'd0,   1'b1, 12'd4095, 12'd4094},
        '{12'd4095, 12'd4095, 12'd4095, 1'b1, 12'd0,    1'b0, 12'd0,   1'b1, 12'd4095, 12'd0},
        '{12'd2000, 12'd0,    12'd4095, 1'b1, 12'd2048, 1'b0, 12'd0,   1'b1, 12'd2000, 12'd1000},
        // duplicate minimum, then duplicate maximum
        '{12'd4095, 12'd0,    12'd0,    1'b1, 12'd4095, 1'b0, 12'd0,   1'b0, 12'd0,    12'd0},
        '{12'd0,    12'd4095, 12'd4095, 1'b0, 12'd0,    1'b0, 12'd0,   1'b0, 12'd0,    12'd0},
        '{12'hAAA,  12'h555,  12'hFFF,  1'b1, 12'd1,    1'b0, 12'd0,   1'b0, 12'd0,    12'd0},
        // gain changed in the middle of a group
        '{12'h555,  12'hAAA,  12'h000,  1'b1, 12'hAAA,  1'b1, 12'h555, 1'b0, 12'd0,    12'd0},
        '{12'd1234, 12'd1234, 12'd4000, 1'b0, 12'd0,    1'b1, 12'd429, 1'b0, 12'd0,    12'd0}
    };

    task automatic clear_group();
        tm_count = '0;
        tm_sum   = '0;
        tm_min   = MIN_RESET;
        tm_max   = '0;
    endtask

    task automatic absorb_sample(input logic [DATA_W-1:0] s);
        group_result_t     r;
        logic [SUM_W-1:0]  trimmed;
        logic [PROD_W-1:0] prod;
        tm_sum = tm_sum + SUM_W'(s);
        if (s < tm_min) tm_min = s;
        if (s > tm_max) tm_max = s;
        tm_count = tm_count + 1'b1;
        if (tm_count == SAMPLE_COUNT) begin
            trimmed = tm_sum - SUM_W'(tm_min) - SUM_W'(tm_max);
            r.avg   = DATA_W'(trimmed / SUM_W'(SAMPLE_COUNT - 2));
            prod    = PROD_W'(r.avg) * PROD_W'(tm_gain);
            r.conc  = prod[PROD_W-1:DATA_W];
            pending_results.push_back(typed_on ? typed_res : r);
            clear_group();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic write_gain(input logic [DATA_W-1:0] g);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tm_gain  = g;
        gain_writes++;
    endtask

    // lower valid, wait for every expected result, then let the back end go quiet
    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic offer_sample(input logic [DATA_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_sample <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        absorb_sample(v);
        samples_sent++;
    endtask

    task automatic gen_sample(output logic [DATA_W-1:0] v);
        int pick;
        int near;
        if (tm_count == 0) begin
            pick = $urandom_range(0, 99);
            src_mode = (pick < 45) ? SRC_UNIFORM :
                       (pick < 70) ? SRC_CLUSTER :
                       (pick < 88) ? SRC_EXTREME : SRC_FLAT;
            src_center = DATA_W'($urandom_range(0, 4095));
        end
        case (src_mode)
            SRC_UNIFORM: v = DATA_W'($urandom_range(0, 4095));
            SRC_CLUSTER: begin
                near = int'(src_center) + $urandom_range(0, 60) - 30;
                if (near < 0) near = 0;
                if (near > 4095) near = 4095;
                v = DATA_W'(near);
            end
            SRC_EXTREME: begin
                pick = $urandom_range(0, 4);
                v = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : (pick == 2) ? 12'd1 :
                    (pick == 3) ? 12'd4094 : DATA_W'($urandom_range(0, 4095));
            end
            default: v = src_center;
        endcase
    endtask

    // output side: stall pattern and one long hold-off
    initial begin
        i_ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_go && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 9) < 3) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(20, 90)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        group_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, trimmed_average", o_trimmed_average, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_trimmed_average !== want.avg)
                    report_mismatch("trimmed_average", o_trimmed_average, want.avg);
                if (o_concentration !== want.conc)
                    report_mismatch("concentration", o_concentration, want.conc);
            end
            results_seen++;
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results still expected", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [DATA_W-1:0] v;
        int                random_sent;
        int                phase_no;
        int                phase_len;
        int                pick;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_sample    = '0;
        tm_gain     = GAIN_RESET;
        typed_on    = 1'b0;
        clear_group();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].gain_we) begin
                settle_block();
                write_gain(rows[r].gain);
            end
            typed_on  = rows[r].typed;
            typed_res = '{avg: rows[r].exp_avg, conc: rows[r].exp_conc};
            for (int i = 0; i < SAMPLE_COUNT; i++) begin
                if (i == SAMPLE_COUNT / 2 && rows[r].mid_we) begin
                    settle_block();
                    write_gain(rows[r].mid_gain);
                end
                v = (i == 0) ? rows[r].first : (i == SAMPLE_COUNT - 1) ? rows[r].last
                                                                     : rows[r].base;
                offer_sample(v);
            end
            typed_on = 1'b0;
        end
        settle_block();

        random_sent = 0;
        phase_no    = 0;
        while (random_sent < RANDOM_ITEMS) begin
            phase_len = (phase_no == 2) ? 240 : $urandom_range(15, 110);
            if (phase_no == 2) hold_go = 1'b1;
            for (int k = 0; k < phase_len; k++) begin
                gen_sample(v);
                offer_sample(v);
                random_sent++;
            end
            settle_block();
            pick = $urandom_range(0, 5);
            write_gain((pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : (pick == 2) ? GAIN_RESET :
                       DATA_W'($urandom_range(0, 4095)));
            phase_no++;
        end
        settle_block();

        $display("sent %0d samples, checked %0d group results across %0d gain writes",
                 samples_sent, results_seen, gain_writes);
        $display("included a %0d-cycle output hold-off and full drains between phases",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
